// ----- rtl/core/rau_pkg.sv -----
// Package with the beat types, operation codes and sizing constants of the rational unit.
`timescale 1ns / 1ps
package rau_pkg;

   localparam int unsigned DefaultValueWidth = 32;
   localparam int unsigned FieldWidth = 32;

   localparam logic [2:0] OP_NORMALIZE = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_SUBTRACT  = 3'd2;
   localparam logic [2:0] OP_MULTIPLY  = 3'd3;
   localparam logic [2:0] OP_DIVIDE    = 3'd4;
   localparam logic [2:0] OP_NEGATE    = 3'd5;
   localparam logic [2:0] OP_COMPARE   = 3'd6;
   localparam logic [2:0] OP_UNDEFINED = 3'd7;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [1:0] REL_LESS    = 2'd0;
   localparam logic [1:0] REL_EQUAL   = 2'd1;
   localparam logic [1:0] REL_GREATER = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic [30:0]        result_den;
      logic [1:0]         relation;
      logic [1:0]         status;
   } rsp_type;

endpackage

// ----- rtl/core/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit with its sequencer and shared datapath.
`timescale 1ns / 1ps
// One beat is taken when start is high and busy is low; busy then stays high until the
// result is shown on rsp_ for one cycle with rsp_valid, which the receiver cannot stall.
// Each operand magnitude passes one shift-add multiplier step per bit (two products for
// multiply and divide, three for add and subtract; normalize and negate skip the products),
// then a binary GCD that removes one bit or does one subtract per cycle, then two restoring
// divisions by the GCD at one quotient bit per cycle. Errors finish at once and compare
// finishes after its two products and the signed sum.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int unsigned W  = VALUE_WIDTH;
   localparam int unsigned PW = 2 * VALUE_WIDTH;
   localparam int unsigned CW = $clog2(PW + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL1  = 4'd1;
   localparam logic [3:0] ST_MUL2  = 4'd2;
   localparam logic [3:0] ST_SUM   = 4'd3;
   localparam logic [3:0] ST_GCD   = 4'd4;
   localparam logic [3:0] ST_DIVN  = 4'd5;
   localparam logic [3:0] ST_DIVD  = 4'd6;
   localparam logic [3:0] ST_CHECK = 4'd7;
   localparam logic [3:0] ST_MUL3  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [W-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic          ans_ff, ans_in, bns_ff, bns_in;
   logic [PW-1:0] p_ff, p_in, q_ff, q_in, r_ff, r_in;
   logic          rneg_ff, rneg_in;
   logic [PW-1:0] x_ff, x_in, y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] sh_ff, sh_in;
   logic [PW-1:0] g_ff, g_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic          valid_ff, valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [W-1:0]  ra_n, ra_d, rb_n, rb_d;
   logic          sa_n, sa_d, sb_n, sb_d;
   logic          uses_b;
   logic [PW-1:0] mul_a, add_acc;
   logic [W-1:0]  mul_b;
   logic [PW:0]   trial;
   logic [PW-1:0] lim;

   function automatic logic [W-1:0] mag_of(input logic [FieldWidth-1:0] raw);
      logic [W-1:0] x;
      x = raw[W-1:0];
      return x[W-1] ? (~x + 1'b1) : x;
   endfunction

   assign ra_n = mag_of(req_data.a_num);
   assign ra_d = mag_of(req_data.a_den);
   assign rb_n = mag_of(req_data.b_num);
   assign rb_d = mag_of(req_data.b_den);
   assign sa_n = req_data.a_num[W-1];
   assign sa_d = req_data.a_den[W-1];
   assign sb_n = req_data.b_num[W-1];
   assign sb_d = req_data.b_den[W-1];
   assign uses_b = (req_data.operation == OP_ADD) || (req_data.operation == OP_SUBTRACT) ||
      (req_data.operation == OP_MULTIPLY) || (req_data.operation == OP_DIVIDE) ||
      (req_data.operation == OP_COMPARE);
   assign lim = PW'(1) << (W - 1);

   // Shared shift-add multiplier: x holds the shifted multiplicand, y the multiplier.
   assign mul_a   = x_ff;
   assign mul_b   = y_ff[W-1:0];
   assign add_acc = r_ff + (mul_b[0] ? mul_a : '0);
   assign trial   = {rem_ff, quo_ff[PW-1]} - {1'b0, g_ff};

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      ans_in = ans_ff; bns_in = bns_ff;
      p_in = p_ff; q_in = q_ff; r_in = r_ff; rneg_in = rneg_ff;
      x_in = x_ff; y_in = y_ff; cnt_in = cnt_ff; sh_in = sh_ff; g_in = g_ff;
      rem_in = rem_ff; quo_in = quo_ff;
      valid_in = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !valid_ff) begin
               op_in = req_data.operation;
               an_in = ra_n; ad_in = ra_d; bn_in = rb_n; bd_in = rb_d;
               ans_in = (sa_n != sa_d) && (ra_n != '0);
               bns_in = (sb_n != sb_d) && (rb_n != '0);
               rsp_in = '{result_num: '0, result_den: 31'd1, relation: REL_LESS,
                          status: STATUS_OK};
               if (req_data.operation == OP_UNDEFINED) begin
                  valid_in = 1'b1;
               end else if (ra_d == '0 || (uses_b && rb_d == '0) ||
                            (req_data.operation == OP_DIVIDE && rb_n == '0)) begin
                  rsp_in.status = STATUS_ZERO_DEN;
                  valid_in = 1'b1;
               end else if (req_data.operation == OP_NORMALIZE ||
                            req_data.operation == OP_NEGATE) begin
                  p_in = PW'(ra_n);
                  q_in = PW'(ra_d);
                  rneg_in = ((sa_n != sa_d) != (req_data.operation == OP_NEGATE)) &&
                            (ra_n != '0);
                  state_in = ST_GCD;
                  x_in = PW'(ra_n); y_in = PW'(ra_d); sh_in = '0;
               end else begin
                  // First product: a_num times b_den (b_num for multiply).
                  x_in = PW'(ra_n);
                  y_in = PW'(req_data.operation == OP_MULTIPLY ? rb_n : rb_d);
                  r_in = '0; cnt_in = CW'(W);
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1, ST_MUL2, ST_MUL3: begin
            r_in = add_acc;
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               r_in = '0;
               case (state_ff)
                  ST_MUL1: begin
                     p_in = add_acc;
                     if (op_ff == OP_MULTIPLY || op_ff == OP_DIVIDE) begin
                        x_in = PW'(ad_ff);
                        y_in = PW'(op_ff == OP_MULTIPLY ? bd_ff : bn_ff);
                        state_in = ST_MUL3;
                     end else begin
                        x_in = PW'(bn_ff); y_in = PW'(ad_ff);
                        state_in = ST_MUL2;
                     end
                  end
                  ST_MUL2: begin
                     q_in = add_acc;
                     x_in = PW'(ad_ff); y_in = PW'(bd_ff);
                     state_in = ST_SUM;
                  end
                  default: begin
                     q_in = add_acc;
                     rneg_in = (ans_ff != bns_ff) && (p_ff != '0);
                     x_in = p_ff; y_in = add_acc; sh_in = '0;
                     state_in = ST_GCD;
                  end
               endcase
               cnt_in = CW'(W);
            end
         end
         ST_SUM: begin
            // a*bd in p, b*ad in q; signed sum with the sign of b flipped for subtract and compare.
            begin : sum_blk
               logic qn;
               logic pn;
               pn = ans_ff;
               qn = (op_ff == OP_ADD) ? bns_ff : ~bns_ff;
               if (pn == qn) begin
                  p_in = p_ff + q_ff; rneg_in = pn;
               end else if (p_ff >= q_ff) begin
                  p_in = p_ff - q_ff; rneg_in = pn;
               end else begin
                  p_in = q_ff - p_ff; rneg_in = qn;
               end
            end
            if (op_ff == OP_COMPARE) begin
               rsp_in.relation = (p_in == '0) ? REL_EQUAL :
                                 (rneg_in ? REL_LESS : REL_GREATER);
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // Denominator product ad*bd, reusing the multiplier.
               r_in = '0; cnt_in = CW'(W);
               x_in = PW'(ad_ff); y_in = PW'(bd_ff);
               state_in = ST_MUL3;
               op_in = OP_NORMALIZE;
               ans_in = rneg_in; bns_in = 1'b0;
            end
         end
         ST_GCD: begin
            // Binary GCD on x and y; sh counts the common factors of two.
            if (x_ff == '0 || y_ff == '0) begin
               g_in = (x_ff | y_ff) << sh_ff;
               if (p_ff == '0) begin
                  q_in = PW'(1);
                  state_in = ST_CHECK;
               end else begin
                  rem_in = '0; quo_in = p_ff; cnt_in = CW'(PW);
                  state_in = ST_DIVN;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1; y_in = y_ff >> 1; sh_in = sh_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         ST_DIVN, ST_DIVD: begin
            quo_in = {quo_ff[PW-2:0], ~trial[PW]};
            rem_in = trial[PW] ? {rem_ff[PW-2:0], quo_ff[PW-1]} : trial[PW-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               cnt_in = CW'(PW);
               if (state_ff == ST_DIVN) begin
                  p_in = {quo_ff[PW-2:0], ~trial[PW]};
                  rem_in = '0; quo_in = q_ff;
                  state_in = ST_DIVD;
               end else begin
                  q_in = {quo_ff[PW-2:0], ~trial[PW]};
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if ((rneg_ff ? (p_ff > lim) : (p_ff > lim - 1'b1)) || q_ff > lim - 1'b1) begin
               rsp_in.status = STATUS_OVERFLOW;
            end else begin
               rsp_in.result_num = FieldWidth'($signed(rneg_ff ? (~p_ff[W-1:0] + 1'b1)
                                                               : p_ff[W-1:0]));
               rsp_in.result_den = 31'(q_ff[W-1:0]);
            end
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (valid_in) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      ans_ff <= ans_in; bns_ff <= bns_in;
      p_ff <= p_in; q_ff <= q_in; r_ff <= r_in; rneg_ff <= rneg_in;
      x_ff <= x_in; y_ff <= y_in; cnt_ff <= cnt_in; sh_ff <= sh_in; g_ff <= g_in;
      rem_ff <= rem_in; quo_ff <= quo_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe lasted two cycles");
   a_den_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_OK && rsp_data.relation == REL_LESS)
      |-> rsp_data.result_den != '0) else $error("zero denominator on good result");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> rsp_data.result_num == '0)
      else $error("error result not cleared");
`endif

endmodule

// ----- tb/rational_arithmetic_unit_tb.sv -----
// Self-checking testbench for the rational arithmetic unit with a fraction predictor.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
   import rau_pkg::*;

   localparam int unsigned CycleLimit = 10000000;

   typedef struct {
      req_type req;
      logic    has_fixed;
      rsp_type fixed;
   } vector_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type     pending_results[$];
   int unsigned error_count = 0;
   int unsigned beats_sent = 0;
   int unsigned results_seen = 0;
   int unsigned cycle_count = 0;
   vector_type  vectors[$];

   rational_arithmetic_unit u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Unsigned gcd of two magnitudes.
   function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Exact fraction result of one command.
   function automatic rsp_type fraction_result(input req_type r);
      rsp_type     o;
      logic        an_neg, ad_neg, bn_neg, bd_neg, uses_b, p_neg, q_neg, n_neg;
      logic [63:0] an, ad, bn, bd, p, q, n, d, g;
      o = '0;
      o.result_den = 31'd1;
      an_neg = r.a_num[31]; an = an_neg ? 64'(-r.a_num) : 64'(r.a_num);
      ad_neg = r.a_den[31]; ad = ad_neg ? 64'(-r.a_den) : 64'(r.a_den);
      bn_neg = r.b_num[31]; bn = bn_neg ? 64'(-r.b_num) : 64'(r.b_num);
      bd_neg = r.b_den[31]; bd = bd_neg ? 64'(-r.b_den) : 64'(r.b_den);
      an = an & 64'hFFFF_FFFF; ad = ad & 64'hFFFF_FFFF;
      bn = bn & 64'hFFFF_FFFF; bd = bd & 64'hFFFF_FFFF;
      if (r.operation == OP_UNDEFINED) return o;
      uses_b = r.operation inside {OP_ADD, OP_SUBTRACT, OP_MULTIPLY, OP_DIVIDE, OP_COMPARE};
      if (ad == 0 || (uses_b && bd == 0) || (r.operation == OP_DIVIDE && bn == 0)) begin
         o.status = STATUS_ZERO_DEN;
         return o;
      end
      an_neg = (an_neg != ad_neg) && an != 0;
      bn_neg = (bn_neg != bd_neg) && bn != 0;
      n_neg = an_neg; n = an; d = ad;
      case (r.operation)
         OP_NEGATE: n_neg = !an_neg && an != 0;
         OP_ADD, OP_SUBTRACT, OP_COMPARE: begin
            p = an * bd; p_neg = an_neg;
            q = bn * ad; q_neg = (r.operation == OP_ADD) ? bn_neg : (!bn_neg && q != 0);
            if (p_neg == q_neg) begin
               n = p + q; n_neg = p_neg;
            end else if (p >= q) begin
               n = p - q; n_neg = p_neg;
            end else begin
               n = q - p; n_neg = q_neg;
            end
            if (n == 0) n_neg = 1'b0;
            d = ad * bd;
            if (r.operation == OP_COMPARE) begin
               o.relation = (n == 0) ? REL_EQUAL : (n_neg ? REL_LESS : REL_GREATER);
               return o;
            end
         end
         OP_MULTIPLY: begin
            n = an * bn; n_neg = (an_neg != bn_neg) && n != 0; d = ad * bd;
         end
         OP_DIVIDE: begin
            n = an * bd; n_neg = (an_neg != bn_neg) && n != 0; d = ad * bn;
         end
         default: ;
      endcase
      g = gcd_of(n, d);
      if (g != 0) begin
         n = n / g;
         d = d / g;
      end
      if (n == 0) d = 1;
      if ((n_neg ? n > 64'h8000_0000 : n > 64'h7FFF_FFFF) || d > 64'h7FFF_FFFF) begin
         o.status = STATUS_OVERFLOW;
         return o;
      end
      o.result_num = n_neg ? -32'(n) : 32'(n);
      o.result_den = 31'(d);
      return o;
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0: return 32'($signed($urandom_range(0, 20)) - 10);
         1: return 32'($urandom_range(0, 1000)) - 32'd500;
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_vector(input logic [2:0] op, input logic [31:0] an, input logic [31:0] ad,
                             input logic [31:0] bn, input logic [31:0] bd, input logic fixed,
                             input logic [31:0] rn, input logic [30:0] rd,
                             input logic [1:0] rel, input logic [1:0] st);
      vector_type v;
      v.req = '{operation: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
      v.has_fixed = fixed;
      v.fixed = '{result_num: rn, result_den: rd, relation: rel, status: st};
      vectors.push_back(v);
   endtask

   task automatic send_beat(input req_type r, input logic fixed, input rsp_type f,
                            input logic allow_gap);
      int unsigned gap;
      rsp_type     model;
      model = fraction_result(r);
      if (fixed && model != f) begin
         $error("Predictor disagrees with table row: expected %h, predicted %h", f, model);
         error_count++;
      end
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(fixed ? f : model);
      beats_sent++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (pending_results.size() == 0) begin
            $error("Result beat with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_num !== want.result_num) begin
               $error("result_num: expected %0d, actual %0d", want.result_num,
                      rsp_data.result_num);
               error_count++;
            end
            if (rsp_data.result_den !== want.result_den) begin
               $error("result_den: expected %0d, actual %0d", want.result_den,
                      rsp_data.result_den);
               error_count++;
            end
            if (rsp_data.relation !== want.relation) begin
               $error("relation: expected %0d, actual %0d", want.relation, rsp_data.relation);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_type r;
      rsp_type none;
      none = '0;
      add_vector(OP_NORMALIZE, 32'sd4, -32'sd6, 0, 0, 1, -32'sd2, 31'd3, REL_LESS, STATUS_OK);
      add_vector(OP_NORMALIZE, 32'sd0, -32'sd7, 0, 0, 1, 32'sd0, 31'd1, REL_LESS, STATUS_OK);
      add_vector(OP_NORMALIZE, 32'sd1, 32'sd0, 1, 1, 1, 0, 31'd1, REL_LESS, STATUS_ZERO_DEN);
      add_vector(OP_NEGATE, 32'sd3, 32'sd5, 7, 0, 1, -32'sd3, 31'd5, REL_LESS, STATUS_OK);
      add_vector(OP_NEGATE, 32'h8000_0000, 32'sd1, 0, 0, 1, 0, 31'd1, REL_LESS,
                 STATUS_OVERFLOW);
      add_vector(OP_NORMALIZE, 32'h8000_0000, 32'sd1, 0, 1, 1, 32'h8000_0000, 31'd1,
                 REL_LESS, STATUS_OK);
      add_vector(OP_NORMALIZE, 32'sd1, 32'h8000_0000, 0, 1, 1, 0, 31'd1, REL_LESS,
                 STATUS_OVERFLOW);
      add_vector(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 1, 32'sd5, 31'd6, REL_LESS,
                 STATUS_OK);
      add_vector(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd0, 1, 0, 31'd1, REL_LESS,
                 STATUS_ZERO_DEN);
      add_vector(OP_SUBTRACT, 32'sd1, 32'sd2, 32'sd1, 32'sd2, 1, 0, 31'd1, REL_LESS,
                 STATUS_OK);
      add_vector(OP_MULTIPLY, 32'sd2, 32'sd3, -32'sd3, 32'sd4, 1, -32'sd1, 31'd2, REL_LESS,
                 STATUS_OK);
      add_vector(OP_MULTIPLY, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF, 32'sd1, 1, 0, 31'd1,
                 REL_LESS, STATUS_OVERFLOW);
      add_vector(OP_DIVIDE, 32'sd1, 32'sd2, 32'sd0, 32'sd5, 1, 0, 31'd1, REL_LESS,
                 STATUS_ZERO_DEN);
      add_vector(OP_DIVIDE, 32'sd1, 32'sd2, -32'sd3, 32'sd4, 1, -32'sd2, 31'd3, REL_LESS,
                 STATUS_OK);
      add_vector(OP_COMPARE, 32'sd1, 32'sd2, 32'sd2, 32'sd4, 1, 0, 31'd1, REL_EQUAL,
                 STATUS_OK);
      add_vector(OP_COMPARE, -32'sd1, 32'sd2, 32'sd1, 32'sd3, 1, 0, 31'd1, REL_LESS,
                 STATUS_OK);
      add_vector(OP_COMPARE, 32'sd1, -32'sd2, -32'sd1, 32'sd1, 1, 0, 31'd1, REL_GREATER,
                 STATUS_OK);
      add_vector(OP_UNDEFINED, 32'sd5, 32'sd0, 32'sd5, 32'sd0, 1, 0, 31'd1, REL_LESS,
                 STATUS_OK);
      add_vector(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                 0, 0, 0, 0);
      add_vector(OP_SUBTRACT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                 0, 0, 0, 0);
      add_vector(OP_DIVIDE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 0,
                 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) send_beat(vectors[i].req, vectors[i].has_fixed, vectors[i].fixed,
                                     1'b1);

      for (int i = 0; i < 2000; i++) begin
         r.operation = (i % 50 == 0) ? OP_UNDEFINED : 3'($urandom_range(0, 6));
         r.a_num = random_operand();
         r.a_den = random_operand();
         r.b_num = random_operand();
         r.b_den = random_operand();
         if (i == 1000) begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         send_beat(r, 1'b0, none, i < 1800);
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d command beats and %0d result beats over all seven operations,",
               beats_sent, results_seen);
      $display("including zero denominators, overflow and full-range operands.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
